[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros
// assertion macros shared by the rtl modules
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every clock edge outside reset
`define WBPS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every clock edge, reset included
`define WBPS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/wbps_pkg.sv]
// ----------------------------------------------------------------------------
// wbps_pkg
// types and constants of the wildcard byte pattern search
// ----------------------------------------------------------------------------
package wbps_pkg;

    typedef enum logic [1:0] {
        OP_LOAD    = 2'd0,
        OP_SCAN    = 2'd1,
        OP_RESTART = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ST_SEARCH = 2'd0,
        ST_MATCH  = 2'd1,
        ST_END    = 2'd2,
        ST_FOUND  = 2'd3
    } status_t;

    localparam logic       REG_PATTERN_LENGTH = 1'b0;
    localparam logic [9:0] PATTERN_LENGTH_RESET = 10'd1;

    typedef struct packed {
        logic       load_en;
        logic       scan_en;
        logic       clear_en;
        logic [8:0] index;
        logic [7:0] value;
        logic       wild;
        logic [7:0] data;
    } cmd_t;

endpackage

[rtl/wildcard_byte_pattern_search.sv]
// ----------------------------------------------------------------------------
// wildcard_byte_pattern_search
// finds the first match of a wildcard byte pattern in a byte stream
// ----------------------------------------------------------------------------
// channel  direction  handshake           payload
// in       input      in_valid/in_stall   operation pattern_index pattern_value
//                                         wildcard_req data_byte last_byte
// out      output     out_valid/out_stall status match_offset
// cfg      input      apb (psel/penable)  pattern_length at address 0
//
// one item per cycle unless stalled; a beat is first held in the input register,
// then processed when it advances; a scan beat then writes the result register
// all match marks within the active length update together on each scanned byte
// reset clears marks, position and found flag at once; no clearing pass
// in_stall rises only when the input register holds a beat and the result register is full and stalled
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wildcard_byte_pattern_search #(
    parameter int MAX_PATTERN = 512
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  operation,
    input  logic [8:0]  pattern_index,
    input  logic [7:0]  pattern_value,
    input  logic        wildcard_req,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [31:0] match_offset,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int LEN_W = $clog2(MAX_PATTERN + 1);

    logic                in_vld_reg;
    logic [1:0]          op_reg;
    logic [8:0]          idx_reg;
    logic [7:0]          val_reg;
    logic                wild_reg;
    logic [7:0]          data_reg;
    logic                last_reg;
    logic                in_accept;
    logic                advance;

    logic                out_vld_reg;
    wbps_pkg::status_t   out_status_reg;
    wbps_pkg::status_t   res_status;
    logic [31:0]         out_offset_reg;
    logic [31:0]         res_offset;

    logic [9:0]          plen_reg;
    logic [31:0]         pos_reg;
    logic                found_reg;

    logic [31:0]         len32;
    logic [31:0]         len_sat;
    logic [LEN_W-1:0]    len_eff;
    logic [IDX_W-1:0]    last_idx;
    logic                hit;
    wbps_pkg::cmd_t      cmd;
    logic                cfg_wr;

    // config port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == wbps_pkg::REG_PATTERN_LENGTH) ? {22'd0, plen_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plen_reg <= wbps_pkg::PATTERN_LENGTH_RESET;
        end
        else if (cfg_wr && (paddr[2] == wbps_pkg::REG_PATTERN_LENGTH))
        begin
            plen_reg <= pwdata[9:0];
        end
    end

    // input register
    assign advance   = in_vld_reg && (!out_vld_reg || !out_stall);
    assign in_stall  = in_vld_reg && out_vld_reg && out_stall;
    assign in_accept = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            in_vld_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            op_reg   <= operation;
            idx_reg  <= pattern_index;
            val_reg  <= pattern_value;
            wild_reg <= wildcard_req;
            data_reg <= data_byte;
            last_reg <= last_byte;
        end
    end

    // command decode
    always_comb
    begin
        cmd          = '0;
        cmd.index    = idx_reg;
        cmd.value    = val_reg;
        cmd.wild     = wild_reg;
        cmd.data     = data_reg;
        case (op_reg)
            wbps_pkg::OP_LOAD:    cmd.load_en  = advance;
            wbps_pkg::OP_SCAN:    cmd.scan_en  = advance;
            wbps_pkg::OP_RESTART: cmd.clear_en = advance;
            default:              cmd.load_en  = 1'b0;
        endcase
    end

    // active length, clamped to 1..MAX_PATTERN
    assign len32   = 32'(plen_reg);
    assign len_sat = (len32 == 32'd0) ? 32'd1 :
                     (len32 > 32'(MAX_PATTERN)) ? 32'(MAX_PATTERN) : len32;
    assign len_eff  = LEN_W'(len_sat);
    assign last_idx = IDX_W'(len_sat - 32'd1);

    wbps_match_array #(
        .MAX_PATTERN (MAX_PATTERN),
        .IDX_W       (IDX_W),
        .LEN_W       (LEN_W)
    ) u_match_array (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .len_eff  (len_eff),
        .last_idx (last_idx),
        .hit      (hit)
    );

    // result
    always_comb
    begin
        res_offset = 32'd0;
        if (found_reg)
        begin
            res_status = wbps_pkg::ST_FOUND;
        end
        else if (hit)
        begin
            res_status = wbps_pkg::ST_MATCH;
            res_offset = pos_reg - (len_sat - 32'd1);
        end
        else if (last_reg)
        begin
            res_status = wbps_pkg::ST_END;
        end
        else
        begin
            res_status = wbps_pkg::ST_SEARCH;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= 32'd0;
            found_reg <= 1'b0;
        end
        else if (cmd.clear_en)
        begin
            pos_reg   <= 32'd0;
            found_reg <= 1'b0;
        end
        else if (cmd.scan_en)
        begin
            if (pos_reg != 32'hFFFF_FFFF)
            begin
                pos_reg <= pos_reg + 32'd1;
            end
            if (hit)
            begin
                found_reg <= 1'b1;
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (cmd.scan_en)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scan_en)
        begin
            out_status_reg <= res_status;
            out_offset_reg <= res_offset;
        end
    end

    assign out_valid    = out_vld_reg;
    assign status       = out_status_reg;
    assign match_offset = out_offset_reg;

    `WBPS_ASSERT(a_found_sticky, found_reg && !cmd.clear_en |=> found_reg, "found flag dropped")
    `WBPS_ASSERT(a_match_sets_found, cmd.scan_en && !found_reg && hit |=> found_reg && (status == wbps_pkg::ST_MATCH), "match not recorded")
    `WBPS_ASSERT(a_found_reports, cmd.scan_en && found_reg |=> out_valid && (status == wbps_pkg::ST_FOUND), "sticky status lost")
    `WBPS_ASSERT_ALWAYS(a_stall_needs_item, in_stall |-> in_vld_reg, "stall with empty input register")

endmodule

[rtl/wbps_match_array.sv]
// ----------------------------------------------------------------------------
// wbps_match_array
// pattern cells and partial-match marks, positions within the active length updated per byte
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wbps_match_array #(
    parameter int MAX_PATTERN = 512,
    parameter int IDX_W = 9,
    parameter int LEN_W = 10
) (
    input  logic                clk,
    input  logic                rst_n,
    input  wbps_pkg::cmd_t      cmd,
    input  logic [LEN_W-1:0]    len_eff,
    input  logic [IDX_W-1:0]    last_idx,
    output logic                hit
);

    logic [7:0]             pat_byte_reg [MAX_PATTERN];
    logic                   pat_wild_reg [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] mark_reg;
    logic [MAX_PATTERN-1:0] mark_next;
    logic                   idx_ok;
    logic [IDX_W-1:0]       wr_idx;

    assign idx_ok = (32'(cmd.index) < 32'(MAX_PATTERN));
    assign wr_idx = IDX_W'(cmd.index);

    always_ff @(posedge clk)
    begin
        if (cmd.load_en && idx_ok)
        begin
            pat_byte_reg[wr_idx] <= cmd.value;
            pat_wild_reg[wr_idx] <= cmd.wild;
        end
    end

    for (genvar k = 0; k < MAX_PATTERN; k++)
    begin : g_cell
        logic prev;
        logic eq;
        if (k == 0)
        begin : g_first
            assign prev = 1'b1;
        end
        else
        begin : g_rest
            assign prev = mark_reg[k-1];
        end
        assign eq = pat_wild_reg[k] || (pat_byte_reg[k] == cmd.data);
        assign mark_next[k] = (LEN_W'(k) < len_eff) ? (prev && eq) : mark_reg[k];
    end

    assign hit = mark_next[last_idx];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mark_reg <= '0;
        end
        else if (cmd.clear_en)
        begin
            mark_reg <= '0;
        end
        else if (cmd.scan_en)
        begin
            mark_reg <= mark_next;
        end
    end

    `WBPS_ASSERT(a_clear_empties, cmd.clear_en |=> (mark_reg == '0), "marks not cleared")
    `WBPS_ASSERT(a_idle_holds, !cmd.scan_en && !cmd.clear_en |=> $stable(mark_reg), "marks moved without a scan")
    `WBPS_ASSERT_ALWAYS(a_one_cmd, $onehot0({cmd.load_en, cmd.scan_en, cmd.clear_en}), "more than one command")

endmodule
